>>> design/cfopc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfopc_pkg
// Shared widths, types and arithmetic helpers for the complex one-pole
// cascade core.
// ----------------------------------------------------------------------------
package cfopc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 18;
  localparam int VALUE_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int GAIN_MUL_W  = COEF_W + SAMPLE_W;
  localparam int SEC_MUL_W   = COEF_W + VALUE_W;
  localparam int PROD_W      = SEC_MUL_W + 1;
  localparam int ROUND_SHIFT = 16;
  localparam int ROUND_W     = PROD_W - ROUND_SHIFT;
  localparam int SUM_W       = ROUND_W + 1;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_RE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_IM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POLE_RE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POLE_IM = 2'd3;

  localparam logic signed [COEF_W-1:0] GAIN_RE_RESET = 18'sd65536;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [VALUE_W-1:0]  value_t;

  typedef struct packed {
    coef_t re;
    coef_t im;
  } cplx_coef_t;

  // One scaled sample on its way into the cascade.
  typedef struct packed {
    logic   valid;
    logic   restart;
    value_t re;
    value_t im;
  } stage_t;

  // Round half up from Q.31 to Q.15: floor((v + 2^15) / 2^16).
  function automatic logic signed [ROUND_W-1:0] round_q31(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + PROD_W'(32768);
    return t[PROD_W-1:ROUND_SHIFT];
  endfunction

  // Saturate a sum to the 32-bit stage value range.
  function automatic value_t sat32(input logic signed [SUM_W-1:0] v);
    logic top_same;
    top_same = (v[SUM_W-1:VALUE_W-1] == '0) || (v[SUM_W-1:VALUE_W-1] == '1);
    if (top_same) begin
      return v[VALUE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

>>> design/cfopc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfopc_in_if
// Sample channel: one complex Q1.15 sample and a restart flag per item.
// ----------------------------------------------------------------------------
interface cfopc_in_if;
  logic              valid;
  logic              ready;
  cfopc_pkg::sample_t sample_re;
  cfopc_pkg::sample_t sample_im;
  logic              restart;

  modport source (output valid, output sample_re, output sample_im, output restart,
                  input ready);
  modport sink   (input valid, input sample_re, input sample_im, input restart,
                  output ready);
endinterface
`default_nettype wire

>>> design/cfopc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfopc_out_if
// Result channel: one complex Q17.15 value per item.
// ----------------------------------------------------------------------------
interface cfopc_out_if;
  logic              valid;
  logic              ready;
  cfopc_pkg::value_t out_re;
  cfopc_pkg::value_t out_im;

  modport source (output valid, output out_re, output out_im, input ready);
  modport sink   (input valid, input out_re, input out_im, output ready);
endinterface
`default_nettype wire

>>> design/complex_fourth_order_one_pole_cascade_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_fourth_order_one_pole_cascade_core
// Complex gammatone-style filter core: complex gain followed by a cascade of
// identical complex one-pole sections, one complex sample per item.
// ----------------------------------------------------------------------------
// Usage notes.
// Items arrive on the samples channel with a valid/ready handshake and each
// produces exactly one item on the results channel, in order.
// The pipeline has three register stages: the input register, the scaled
// sample register after the complex gain, and the result register after the
// section chain. An accepted item passes through these registers in that order,
// and while the receiver keeps ready high a new item can be accepted in every
// cycle, so the sustained rate is one item per clock.
// The section states sit in flip-flops and their feedback products use only
// the stored values, which is what lets consecutive samples follow directly.
// Setting restart on an item clears all section states before that sample.
// When the receiver holds ready low, the stages fill up behind the result
// register and the samples channel drops ready once every stage is occupied;
// no item is lost or repeated.
// Synchronous reset empties the pipeline, clears the section states and
// loads the coefficients with a unity gain and a zero pole.
// Coefficient registers are written through wr_en, wr_index and wr_data;
// the user must do so only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module complex_fourth_order_one_pole_cascade_core #(
  parameter int SECTIONS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  cfopc_in_if.sink                               samples,
  cfopc_out_if.source                            results,
  input  wire logic                              wr_en,
  input  wire logic [cfopc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [cfopc_pkg::COEF_W-1:0]      wr_data
);

  // Coefficient registers.
  cfopc_pkg::cplx_coef_t gain;
  cfopc_pkg::cplx_coef_t pole;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain.re <= cfopc_pkg::GAIN_RE_RESET;
      gain.im <= '0;
      pole.re <= '0;
      pole.im <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        cfopc_pkg::REG_GAIN_RE: gain.re <= wr_data;
        cfopc_pkg::REG_GAIN_IM: gain.im <= wr_data;
        cfopc_pkg::REG_POLE_RE: pole.re <= wr_data;
        cfopc_pkg::REG_POLE_IM: pole.im <= wr_data;
        default: ;
      endcase
    end
  end

  // Input register. It loads whenever it is empty or its item moves on.
  logic               in_valid;
  logic               in_restart;
  cfopc_pkg::sample_t in_re;
  cfopc_pkg::sample_t in_im;

  cfopc_pkg::stage_t  stage;
  logic               advance;
  logic               stage_load;

  assign stage_load    = !stage.valid || advance;
  assign samples.ready = !in_valid || stage_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
    if (samples.ready) begin
      in_restart <= samples.restart;
      in_re      <= samples.sample_re;
      in_im      <= samples.sample_im;
    end
  end

  // Complex gain b0 into the scaled sample register.
  cfopc_gain u_gain (
    .clk        (clk),
    .rst        (rst),
    .load       (stage_load),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_re      (in_re),
    .in_im      (in_im),
    .gain       (gain),
    .stage      (stage)
  );

  // Section chain, state and result register.
  cfopc_cascade #(
    .SECTIONS (SECTIONS)
  ) u_cascade (
    .clk     (clk),
    .rst     (rst),
    .pole    (pole),
    .stage   (stage),
    .advance (advance),
    .results (results)
  );

endmodule
`default_nettype wire

>>> design/cfopc_gain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfopc_gain
// Complex input gain: multiplies the held sample by b0, rounds to Q.15 and
// registers the scaled sample for the cascade.
// ----------------------------------------------------------------------------
module cfopc_gain (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic                  in_valid,
  input  wire logic                  in_restart,
  input  wire cfopc_pkg::sample_t    in_re,
  input  wire cfopc_pkg::sample_t    in_im,
  input  wire cfopc_pkg::cplx_coef_t gain,
  output cfopc_pkg::stage_t          stage
);

  logic signed [cfopc_pkg::GAIN_MUL_W-1:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [cfopc_pkg::PROD_W-1:0]     acc_re, acc_im;
  logic signed [cfopc_pkg::ROUND_W-1:0]    rnd_re, rnd_im;

  assign p_rr = gain.re * in_re;
  assign p_ii = gain.im * in_im;
  assign p_ir = gain.im * in_re;
  assign p_ri = gain.re * in_im;

  assign acc_re = cfopc_pkg::PROD_W'(p_rr) - cfopc_pkg::PROD_W'(p_ii);
  assign acc_im = cfopc_pkg::PROD_W'(p_ir) + cfopc_pkg::PROD_W'(p_ri);

  assign rnd_re = cfopc_pkg::round_q31(acc_re);
  assign rnd_im = cfopc_pkg::round_q31(acc_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (load) begin
      stage.valid <= in_valid;
    end
    if (load) begin
      stage.restart <= in_restart;
      stage.re      <= cfopc_pkg::sat32(cfopc_pkg::SUM_W'(rnd_re));
      stage.im      <= cfopc_pkg::sat32(cfopc_pkg::SUM_W'(rnd_im));
    end
  end

endmodule
`default_nettype wire

>>> design/cfopc_cascade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfopc_cascade
// The chain of complex one-pole sections with their state registers and the
// result register that drives the output channel.
// ----------------------------------------------------------------------------
module cfopc_cascade #(
  parameter int SECTIONS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfopc_pkg::cplx_coef_t pole,
  input  wire cfopc_pkg::stage_t     stage,
  output logic                       advance,
  cfopc_out_if.source                results
);

  cfopc_pkg::value_t state_re [SECTIONS];
  cfopc_pkg::value_t state_im [SECTIONS];
  cfopc_pkg::value_t state_re_next [SECTIONS];
  cfopc_pkg::value_t state_im_next [SECTIONS];

  assign advance = !results.valid || results.ready;

  // Feedback products use the stored state only; the section sums ripple
  // through the chain within the cycle.
  always_comb begin
    logic signed [cfopc_pkg::SEC_MUL_W-1:0] m_rr, m_ii, m_ir, m_ri;
    logic signed [cfopc_pkg::PROD_W-1:0]    a_re, a_im;
    logic signed [cfopc_pkg::SUM_W-1:0]     s_re, s_im;
    cfopc_pkg::value_t                      x_re, x_im, pr, pi;
    x_re = stage.re;
    x_im = stage.im;
    for (int l = 0; l < SECTIONS; l++) begin
      pr   = stage.restart ? '0 : state_re[l];
      pi   = stage.restart ? '0 : state_im[l];
      m_rr = pole.re * pr;
      m_ii = pole.im * pi;
      m_ir = pole.im * pr;
      m_ri = pole.re * pi;
      a_re = cfopc_pkg::PROD_W'(m_rr) - cfopc_pkg::PROD_W'(m_ii);
      a_im = cfopc_pkg::PROD_W'(m_ir) + cfopc_pkg::PROD_W'(m_ri);
      s_re = cfopc_pkg::SUM_W'(x_re) + cfopc_pkg::SUM_W'(cfopc_pkg::round_q31(a_re));
      s_im = cfopc_pkg::SUM_W'(x_im) + cfopc_pkg::SUM_W'(cfopc_pkg::round_q31(a_im));
      x_re = cfopc_pkg::sat32(s_re);
      x_im = cfopc_pkg::sat32(s_im);
      state_re_next[l] = x_re;
      state_im_next[l] = x_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      for (int l = 0; l < SECTIONS; l++) begin
        state_re[l] <= '0;
        state_im[l] <= '0;
      end
    end else if (advance) begin
      results.valid <= stage.valid;
      if (stage.valid) begin
        for (int l = 0; l < SECTIONS; l++) begin
          state_re[l] <= state_re_next[l];
          state_im[l] <= state_im_next[l];
        end
      end
    end
    if (advance && stage.valid) begin
      results.out_re <= state_re_next[SECTIONS-1];
      results.out_im <= state_im_next[SECTIONS-1];
    end
  end

endmodule
`default_nettype wire
